// ===== hdl/vca_pkg.sv =====
// Shared widths, codes and command types for the voice channel allocator.
package vca_pkg;

  localparam int REQ_W      = 2;
  localparam int PRIO_W     = 8;
  localparam int CLASS_W    = 4;
  localparam int REL_W      = 6;
  localparam int STAT_W     = 2;
  localparam int CHAN_W     = 6;
  localparam int CNT_W      = 7;
  localparam int ACT_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  localparam logic [ACT_W-1:0] ACTIVE_RST = 7'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_GRANTED = 2'd0;
  localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DONE    = 2'd2;

  typedef enum logic [REQ_W-1:0] {
    OP_START    = 2'd0,
    OP_STOP_SRC = 2'd1,
    OP_RELEASE  = 2'd2,
    OP_STOP_ALL = 2'd3
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [PRIO_W-1:0]   prio;
    logic [CLASS_W-1:0]  cls;
    logic [REL_W-1:0]    rel;
    logic                rel_ok;   // release index names an existing channel
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

endpackage

// ===== hdl/voice_channel_allocator.sv =====
// Top level of the voice channel allocator: config registers, front end and back end.
//
// Usage:
//   Requests enter on start/busy: a beat is taken at a rising edge with start high
//   and busy low. The front end classifies it and parks it in a two-entry queue;
//   busy rises only when that queue is full.
//   Each request yields exactly one result beat: done_o is high for one cycle with
//   status_o, channel_index_o and stopped_count_o. The receiver cannot stall, so
//   results are never held back.
//   Config beats (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) write
//   active_channels (index 0) or replace_mode (index 1); ready is always high.
//   Write config only while no request is outstanding.
// Scans (n = active channels, capped at MAX_CHANNELS):
//   The channel table has one read port, so scans look at one channel per cycle.
//   start: up to three scans (pre-stop, allocate, evict) over the n channels;
//   stop by source one scan; release none; stop all walks the n busy bits.
//   Items are processed one at a time, after passing through the queue.
// Reset: all channels free, active_channels = 8, replace_mode = 0, queue empty.
// No clearing pass is needed: busy bits are flops cleared by reset.
module voice_channel_allocator #(
  parameter int MAX_CHANNELS = 64,
  parameter int SOURCE_BITS  = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              start,
  output logic                              busy,
  input  logic [vca_pkg::REQ_W-1:0]         req_type_i,
  input  logic [SOURCE_BITS-1:0]            source_id_i,
  input  logic [vca_pkg::PRIO_W-1:0]        sound_priority_i,
  input  logic [vca_pkg::CLASS_W-1:0]       sound_class_i,
  input  logic [vca_pkg::REL_W-1:0]         release_index_i,
  // config write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [vca_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [vca_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // result channel
  output logic                              done_o,
  output logic [vca_pkg::STAT_W-1:0]        status_o,
  output logic [vca_pkg::CHAN_W-1:0]        channel_index_o,
  output logic [vca_pkg::CNT_W-1:0]         stopped_count_o
);

  logic [vca_pkg::ACT_W-1:0]  active_q;
  logic                       replace_q;
  vca_pkg::head_t             head;
  logic [SOURCE_BITS-1:0]     head_src;
  logic                       pop;

  assign cfg_ready_o = 1'b1;

  // config registers; writes to unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= vca_pkg::ACTIVE_RST;
      replace_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        vca_pkg::CFG_ACTIVE:  active_q  <= cfg_data_i;
        vca_pkg::CFG_REPLACE: replace_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  vca_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SOURCE_BITS  (SOURCE_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type_i),
    .source_id_i      (source_id_i),
    .sound_priority_i (sound_priority_i),
    .sound_class_i    (sound_class_i),
    .release_index_i  (release_index_i),
    .head_o           (head),
    .head_src_o       (head_src),
    .pop_i            (pop)
  );

  vca_engine #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SOURCE_BITS  (SOURCE_BITS)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .active_i        (active_q),
    .replace_i       (replace_q),
    .head_i          (head),
    .head_src_i      (head_src),
    .pop_o           (pop),
    .done_o          (done_o),
    .status_o        (status_o),
    .channel_index_o (channel_index_o),
    .stopped_count_o (stopped_count_o)
  );

endmodule

// ===== hdl/vca_front.sv =====
// Command front end: accepts requests, classifies them and queues them.
module vca_front #(
  parameter int MAX_CHANNELS = 64,
  parameter int SOURCE_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [vca_pkg::REQ_W-1:0]     req_type_i,
  input  logic [SOURCE_BITS-1:0]        source_id_i,
  input  logic [vca_pkg::PRIO_W-1:0]    sound_priority_i,
  input  logic [vca_pkg::CLASS_W-1:0]   sound_class_i,
  input  logic [vca_pkg::REL_W-1:0]     release_index_i,
  output vca_pkg::head_t                head_o,
  output logic [SOURCE_BITS-1:0]        head_src_o,
  input  logic                          pop_i
);

  localparam int AW  = vca_pkg::Q_AW;
  localparam int QCW = vca_pkg::Q_AW + 1;
  localparam logic [QCW-1:0] FULL = QCW'(vca_pkg::Q_DEPTH);

  vca_pkg::cmd_t             in_cmd;
  vca_pkg::cmd_t             cmd_mem_q [vca_pkg::Q_DEPTH];
  logic [SOURCE_BITS-1:0]    src_mem_q [vca_pkg::Q_DEPTH];
  logic [AW-1:0]             wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]             rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0]            count_q, count_d;
  logic                      push;

  always_comb begin
    in_cmd.op     = vca_pkg::op_e'(req_type_i);
    in_cmd.prio   = sound_priority_i;
    in_cmd.cls    = sound_class_i;
    in_cmd.rel    = release_index_i;
    in_cmd.rel_ok = (32'(release_index_i) < MAX_CHANNELS);
  end

  assign busy = (count_q == FULL);
  assign push = start && !busy;

  always_comb begin
    wr_ptr_d = push  ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    case ({push, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_mem_q[wr_ptr_q] <= in_cmd;
      src_mem_q[wr_ptr_q] <= source_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = cmd_mem_q[rd_ptr_q];
  assign head_src_o   = src_mem_q[rd_ptr_q];

endmodule

// ===== hdl/vca_engine.sv =====
// Back end: channel table and the scan sequencer that carries out each command.
module vca_engine #(
  parameter int MAX_CHANNELS = 64,
  parameter int SOURCE_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [vca_pkg::ACT_W-1:0]     active_i,
  input  logic                          replace_i,
  input  vca_pkg::head_t                head_i,
  input  logic [SOURCE_BITS-1:0]        head_src_i,
  output logic                          pop_o,
  output logic                          done_o,
  output logic [vca_pkg::STAT_W-1:0]    status_o,
  output logic [vca_pkg::CHAN_W-1:0]    channel_index_o,
  output logic [vca_pkg::CNT_W-1:0]     stopped_count_o
);

  localparam int CW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NW   = $clog2(MAX_CHANNELS + 1);
  localparam int EW   = SOURCE_BITS + vca_pkg::CLASS_W + vca_pkg::PRIO_W;
  localparam int CNW  = vca_pkg::CNT_W;
  localparam int CHW  = vca_pkg::CHAN_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE_STOP,
    S_ALLOC,
    S_EVICT,
    S_STOP_SRC,
    S_RELEASE,
    S_STOP_ALL
  } state_e;

  state_e                     state_q;
  logic [MAX_CHANNELS-1:0]    busy_q;
  logic [NW-1:0]              issue_q;
  logic                       chk_vld_q;
  logic [CW-1:0]              chk_idx_q;
  vca_pkg::cmd_t              cmd_q;
  logic [SOURCE_BITS-1:0]     src_q;
  logic [CNW-1:0]             stopped_q;
  logic                       done_q;
  logic [vca_pkg::STAT_W-1:0] status_q;
  logic [CW-1:0]              chan_q;
  logic [CNW-1:0]             cnt_out_q;

  // channel table: source, class, priority per channel
  logic [EW-1:0]              mem_q [MAX_CHANNELS];
  logic [EW-1:0]              rd_data_q;

  logic [NW-1:0]              n_s;
  logic                       issue_more;
  logic [CW-1:0]              rd_addr;
  logic [CW-1:0]              rel_idx;
  logic [SOURCE_BITS-1:0]     ent_src;
  logic [vca_pkg::CLASS_W-1:0] ent_cls;
  logic [vca_pkg::PRIO_W-1:0] ent_prio;
  logic                       ent_busy;
  logic                       src_eq, cls_eq;
  logic                       pre_hit, alloc_hit, evict_hit, stop_hit, rel_hit;
  logic                       scanning;
  logic                       scan_end;
  logic                       mem_we;

  always_comb begin
    n_s = (32'(active_i) > MAX_CHANNELS) ? NW'(MAX_CHANNELS) : NW'(active_i);
    issue_more = (issue_q < n_s);
    rd_addr    = issue_q[CW-1:0];
    rel_idx    = CW'(cmd_q.rel);
    {ent_src, ent_cls, ent_prio} = rd_data_q;
    ent_busy   = busy_q[chk_idx_q];
    src_eq     = (ent_src == src_q);
    cls_eq     = (ent_cls == cmd_q.cls);
    pre_hit    = ent_busy && src_eq && (!replace_i || cls_eq);
    // first free channel, or a busy one from the same nonzero source and class
    alloc_hit  = !ent_busy || ((src_q != '0) && src_eq && cls_eq);
    evict_hit  = (ent_prio >= cmd_q.prio);
    stop_hit   = ent_busy && src_eq;
    rel_hit    = cmd_q.rel_ok && busy_q[rel_idx];
    scanning   = state_q inside {S_PRE_STOP, S_ALLOC, S_EVICT, S_STOP_SRC};
    scan_end   = !chk_vld_q && !issue_more;
    mem_we     = chk_vld_q && (((state_q == S_ALLOC) && alloc_hit) ||
                               ((state_q == S_EVICT) && evict_hit));
  end

  assign pop_o = (state_q == S_IDLE) && head_i.valid;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[chk_idx_q] <= {src_q, cmd_q.cls, cmd_q.prio};
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      busy_q    <= '0;
      issue_q   <= '0;
      chk_vld_q <= 1'b0;
      chk_idx_q <= '0;
      cmd_q     <= '0;
      src_q     <= '0;
      stopped_q <= '0;
      done_q    <= 1'b0;
      status_q  <= vca_pkg::STAT_DONE;
      chan_q    <= '0;
      cnt_out_q <= '0;
    end else begin
      done_q <= 1'b0;
      // read pipeline: issue one address a beat, check the one before it
      if (scanning) begin
        chk_vld_q <= issue_more;
        chk_idx_q <= rd_addr;
        if (issue_more) begin
          issue_q <= issue_q + 1'b1;
        end
      end
      case (state_q)
        S_IDLE: begin
          if (head_i.valid) begin
            cmd_q     <= head_i.cmd;
            src_q     <= head_src_i;
            stopped_q <= '0;
            issue_q   <= '0;
            chk_vld_q <= 1'b0;
            case (head_i.cmd.op)
              vca_pkg::OP_START:    state_q <= S_PRE_STOP;
              vca_pkg::OP_STOP_SRC: state_q <= S_STOP_SRC;
              vca_pkg::OP_RELEASE:  state_q <= S_RELEASE;
              vca_pkg::OP_STOP_ALL: state_q <= S_STOP_ALL;
              default:              state_q <= S_IDLE;
            endcase
          end
        end
        S_PRE_STOP: begin
          if (chk_vld_q && pre_hit) begin
            busy_q[chk_idx_q] <= 1'b0;
            stopped_q <= CNW'(1);
            issue_q   <= '0;
            chk_vld_q <= 1'b0;
            state_q   <= S_ALLOC;
          end else if (scan_end) begin
            issue_q <= '0;
            state_q <= S_ALLOC;
          end
        end
        S_ALLOC: begin
          if (chk_vld_q && alloc_hit) begin
            busy_q[chk_idx_q] <= 1'b1;
            done_q    <= 1'b1;
            status_q  <= vca_pkg::STAT_GRANTED;
            chan_q    <= chk_idx_q;
            cnt_out_q <= stopped_q + CNW'(ent_busy);
            chk_vld_q <= 1'b0;
            state_q   <= S_IDLE;
          end else if (scan_end) begin
            issue_q <= '0;
            state_q <= S_EVICT;
          end
        end
        S_EVICT: begin
          if (chk_vld_q && evict_hit) begin
            busy_q[chk_idx_q] <= 1'b1;
            done_q    <= 1'b1;
            status_q  <= vca_pkg::STAT_GRANTED;
            chan_q    <= chk_idx_q;
            cnt_out_q <= stopped_q + CNW'(ent_busy);
            chk_vld_q <= 1'b0;
            state_q   <= S_IDLE;
          end else if (scan_end) begin
            done_q    <= 1'b1;
            status_q  <= vca_pkg::STAT_REFUSED;
            chan_q    <= '0;
            cnt_out_q <= stopped_q;
            state_q   <= S_IDLE;
          end
        end
        S_STOP_SRC: begin
          if (chk_vld_q && stop_hit) begin
            busy_q[chk_idx_q] <= 1'b0;
            done_q    <= 1'b1;
            status_q  <= vca_pkg::STAT_DONE;
            chan_q    <= '0;
            cnt_out_q <= CNW'(1);
            chk_vld_q <= 1'b0;
            state_q   <= S_IDLE;
          end else if (scan_end) begin
            done_q    <= 1'b1;
            status_q  <= vca_pkg::STAT_DONE;
            chan_q    <= '0;
            cnt_out_q <= '0;
            state_q   <= S_IDLE;
          end
        end
        S_RELEASE: begin
          if (rel_hit) begin
            busy_q[rel_idx] <= 1'b0;
          end
          done_q    <= 1'b1;
          status_q  <= vca_pkg::STAT_DONE;
          chan_q    <= '0;
          cnt_out_q <= CNW'(rel_hit);
          state_q   <= S_IDLE;
        end
        S_STOP_ALL: begin
          // walk the busy bits one channel a beat
          if (issue_more) begin
            if (busy_q[rd_addr]) begin
              busy_q[rd_addr] <= 1'b0;
              stopped_q <= stopped_q + 1'b1;
            end
            issue_q <= issue_q + 1'b1;
          end else begin
            done_q    <= 1'b1;
            status_q  <= vca_pkg::STAT_DONE;
            chan_q    <= '0;
            cnt_out_q <= stopped_q;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign channel_index_o = CHW'(chan_q);
  assign stopped_count_o = cnt_out_q;

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for more than one cycle");

  a_grant_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (status_q == vca_pkg::STAT_GRANTED) |-> busy_q[chan_q])
    else $error("granted channel not marked busy");

  a_check_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chk_vld_q |-> (32'(chk_idx_q) < 32'(n_s)))
    else $error("scan checks a channel outside the active range");

  a_start_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (status_q != vca_pkg::STAT_DONE) |-> (cnt_out_q <= CNW'(2)))
    else $error("start request stopped more than two channels");

  a_pop_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q != S_IDLE))
    else $error("command popped but sequencer stayed idle");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for voice_channel_allocator: a directed table, then random config phases.
module tb;

  localparam int NUM_CHANS   = 64;
  localparam int SRC_W       = 16;
  localparam int NUM_PHASES  = 12;
  // Worst correct item: three full scans plus queue, plus the longest sender gap.
  // Roughly 1550 items at that worst case; the limit is several times their total.
  localparam int CYCLE_LIMIT = 1_500_000;
  // Longest scan after the last beat: start with n = 64.
  localparam int SCAN_TAIL   = 3 * NUM_CHANS + 10;

  typedef struct packed {
    vca_pkg::op_e                op;
    logic [SRC_W-1:0]            src;
    logic [vca_pkg::PRIO_W-1:0]  prio;
    logic [vca_pkg::CLASS_W-1:0] cls;
    logic [vca_pkg::REL_W-1:0]   rel;
  } voice_req_t;

  typedef struct packed {
    logic [vca_pkg::STAT_W-1:0] status;
    logic [vca_pkg::CHAN_W-1:0] chan;
    logic [vca_pkg::CNT_W-1:0]  stopped;
  } voice_res_t;

  typedef struct packed {
    voice_req_t req;
    logic       fixed;  // outcome typed in below, not taken from the predictor
    voice_res_t res;
  } dir_row_t;

  // ---------------------------------------------------------------------------
  // DUT and its ports
  // ---------------------------------------------------------------------------
  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           start;
  logic                           busy;
  logic [vca_pkg::REQ_W-1:0]      req_type_i;
  logic [SRC_W-1:0]               source_id_i;
  logic [vca_pkg::PRIO_W-1:0]     sound_priority_i;
  logic [vca_pkg::CLASS_W-1:0]    sound_class_i;
  logic [vca_pkg::REL_W-1:0]      release_index_i;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [vca_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [vca_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                           done_o;
  logic [vca_pkg::STAT_W-1:0]     status_o;
  logic [vca_pkg::CHAN_W-1:0]     channel_index_o;
  logic [vca_pkg::CNT_W-1:0]      stopped_count_o;

  voice_channel_allocator #(
    .MAX_CHANNELS(NUM_CHANS),
    .SOURCE_BITS (SRC_W)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .source_id_i     (source_id_i),
    .sound_priority_i(sound_priority_i),
    .sound_class_i   (sound_class_i),
    .release_index_i (release_index_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .channel_index_o (channel_index_o),
    .stopped_count_o (stopped_count_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the channel table and registers
  // ---------------------------------------------------------------------------
  logic [vca_pkg::ACT_W-1:0]   act_sh;
  logic                        repl_sh;
  bit                          chan_on   [NUM_CHANS];
  logic [SRC_W-1:0]            chan_src  [NUM_CHANS];
  logic [vca_pkg::CLASS_W-1:0] chan_cls  [NUM_CHANS];
  logic [vca_pkg::PRIO_W-1:0]  chan_prio [NUM_CHANS];

  voice_res_t pending_outcomes [$];  // one entry per accepted beat, oldest first
  int         errors    = 0;
  int         cycle_cnt = 0;
  bit         idle_on;  // sender gaps allowed in the current stretch
  bit         calm;     // last phase: no gaps at all

  // Phase plan: register extremes early (no channels, one, over the cap, full),
  // then a spread of small sizes, which keep the table full and eviction busy.
  int phase_act [NUM_PHASES] = '{0, 1, 127, 8, 2, 64, 5, 3, 16, 8, 4, 12};
  int phase_rep [NUM_PHASES] = '{1, 0, 1, 0, 1, 0, 0, 1, 1, 0, 1, 0};
  int phase_len [NUM_PHASES] = '{20, 140, 120, 140, 140, 120, 140, 140, 140, 140, 140, 140};

  // Directed table, run from reset values (8 channels, replace_mode 0).
  dir_row_t dir_rows [24] = '{
    // idle table: release of an idle channel above active_channels, stop all, stop source 0
    '{'{vca_pkg::OP_RELEASE,  16'h0000, 8'h00, 4'h0, 6'd63}, 1'b1,
      '{vca_pkg::STAT_DONE,    6'd0, 7'd0}},
    '{'{vca_pkg::OP_STOP_ALL, 16'h0000, 8'h00, 4'h0, 6'd0},  1'b1,
      '{vca_pkg::STAT_DONE,    6'd0, 7'd0}},
    '{'{vca_pkg::OP_STOP_SRC, 16'h0000, 8'h00, 4'h0, 6'd0},  1'b1,
      '{vca_pkg::STAT_DONE,    6'd0, 7'd0}},
    // field extremes on start
    '{'{vca_pkg::OP_START,    16'h0000, 8'h00, 4'h0, 6'd0},  1'b1,
      '{vca_pkg::STAT_GRANTED, 6'd0, 7'd0}},
    '{'{vca_pkg::OP_START,    16'hFFFF, 8'hFF, 4'hF, 6'd63}, 1'b1,
      '{vca_pkg::STAT_GRANTED, 6'd1, 7'd0}},
    // source zero still gets its older sound stopped before allocation
    '{'{vca_pkg::OP_START,    16'h0000, 8'd10, 4'h0, 6'd0},  1'b1,
      '{vca_pkg::STAT_GRANTED, 6'd0, 7'd1}},
    '{'{vca_pkg::OP_START,    16'hFFFF, 8'd5,  4'hF, 6'd0},  1'b1,
      '{vca_pkg::STAT_GRANTED, 6'd1, 7'd1}},
    // fill the rest of the table
    '{'{vca_pkg::OP_START,    16'd1,    8'd100, 4'd3, 6'd0}, 1'b0, '0},
    '{'{vca_pkg::OP_START,    16'd2,    8'd100, 4'd3, 6'd0}, 1'b0, '0},
    '{'{vca_pkg::OP_START,    16'd3,    8'd100, 4'd3, 6'd0}, 1'b0, '0},
    '{'{vca_pkg::OP_START,    16'd4,    8'd100, 4'd3, 6'd0}, 1'b0, '0},
    '{'{vca_pkg::OP_START,    16'd5,    8'd100, 4'd3, 6'd0}, 1'b0, '0},
    '{'{vca_pkg::OP_START,    16'd6,    8'd100, 4'd3, 6'd0}, 1'b0, '0},
    // full table: eviction by priority, then nothing qualifies
    '{'{vca_pkg::OP_START,    16'd7,    8'd50,  4'd1, 6'd0}, 1'b0, '0},
    '{'{vca_pkg::OP_START,    16'd8,    8'hFF,  4'd0, 6'd0}, 1'b1,
      '{vca_pkg::STAT_REFUSED, 6'd0, 7'd0}},
    // equal priority value qualifies for eviction
    '{'{vca_pkg::OP_START,    16'd9,    8'd100, 4'd0, 6'd0}, 1'b0, '0},
    '{'{vca_pkg::OP_START,    16'd2,    8'd128, 4'd3, 6'd0}, 1'b0, '0},
    // stop by source: hit and miss
    '{'{vca_pkg::OP_STOP_SRC, 16'hFFFF, 8'h00, 4'h0, 6'd0},  1'b0, '0},
    '{'{vca_pkg::OP_STOP_SRC, 16'h1234, 8'h00, 4'h0, 6'd0},  1'b1,
      '{vca_pkg::STAT_DONE,    6'd0, 7'd0}},
    '{'{vca_pkg::OP_RELEASE,  16'h0000, 8'h00, 4'h0, 6'd0},  1'b0, '0},
    '{'{vca_pkg::OP_RELEASE,  16'h0000, 8'h00, 4'h0, 6'd2},  1'b0, '0},
    '{'{vca_pkg::OP_START,    16'hAAAA, 8'h55, 4'hA, 6'h2A}, 1'b0, '0},
    '{'{vca_pkg::OP_STOP_ALL, 16'h0000, 8'h00, 4'h0, 6'd0},  1'b0, '0},
    // empty again after stop all
    '{'{vca_pkg::OP_START,    16'h5555, 8'hAA, 4'h5, 6'h15}, 1'b1,
      '{vca_pkg::STAT_GRANTED, 6'd0, 7'd0}}
  };

  function automatic void clear_shadow();
    act_sh  = vca_pkg::ACTIVE_RST;
    repl_sh = 1'b0;
    for (int c = 0; c < NUM_CHANS; c++) begin
      chan_on[c]   = 1'b0;
      chan_src[c]  = '0;
      chan_cls[c]  = '0;
      chan_prio[c] = '0;
    end
  endfunction

  function automatic int used_chans();
    return (act_sh > NUM_CHANS) ? NUM_CHANS : int'(act_sh);
  endfunction

  // Applies one request to the shadow table and returns the outcome it must produce.
  task automatic predict_outcome(input voice_req_t r, output voice_res_t res);
    int n;
    int c;
    int stopped;
    n       = used_chans();
    stopped = 0;
    res     = '{vca_pkg::STAT_DONE, '0, '0};
    case (r.op)
      vca_pkg::OP_START: begin
        // one older sound goes first: same source, and same class in replace mode
        for (c = 0; c < n; c++) begin
          if (chan_on[c] && chan_src[c] == r.src &&
              (!repl_sh || chan_cls[c] == r.cls)) begin
            chan_on[c] = 1'b0;
            stopped++;
            break;
          end
        end
        // first free channel, or reuse of a busy one from the same nonzero source and class
        c = 0;
        while (c < n && chan_on[c]) begin
          if (r.src != '0 && chan_src[c] == r.src && chan_cls[c] == r.cls) begin
            chan_on[c] = 1'b0;
            stopped++;
            break;
          end
          c++;
        end
        // table full: evict the first channel whose priority value is >= the request's
        if (c == n) begin
          c = 0;
          while (c < n && chan_prio[c] < r.prio) c++;
          if (c < n && chan_on[c]) begin
            chan_on[c] = 1'b0;
            stopped++;
          end
        end
        if (c < n) begin
          chan_on[c]   = 1'b1;
          chan_src[c]  = r.src;
          chan_cls[c]  = r.cls;
          chan_prio[c] = r.prio;
          res.status   = vca_pkg::STAT_GRANTED;
          res.chan     = vca_pkg::CHAN_W'(c);
        end else begin
          res.status = vca_pkg::STAT_REFUSED;
        end
      end
      vca_pkg::OP_STOP_SRC: begin
        for (c = 0; c < n; c++) begin
          if (chan_on[c] && chan_src[c] == r.src) begin
            chan_on[c] = 1'b0;
            stopped++;
            break;
          end
        end
      end
      vca_pkg::OP_RELEASE: begin
        // any index of the table counts, even above active_channels
        if (chan_on[r.rel]) begin
          chan_on[r.rel] = 1'b0;
          stopped++;
        end
      end
      vca_pkg::OP_STOP_ALL: begin
        for (c = 0; c < n; c++) begin
          if (chan_on[c]) begin
            chan_on[c] = 1'b0;
            stopped++;
          end
        end
      end
      default: ;
    endcase
    res.stopped = vca_pkg::CNT_W'(stopped);
  endtask

  // Random request. Sources come mostly from a small pool so that older sounds
  // get stopped and the table fills; the rest covers zero and the full range.
  function automatic voice_req_t random_request(int n);
    voice_req_t r;
    int         k;
    k = $urandom_range(0, 99);
    if (k < 66)      r.op = vca_pkg::OP_START;
    else if (k < 78) r.op = vca_pkg::OP_STOP_SRC;
    else if (k < 95) r.op = vca_pkg::OP_RELEASE;
    else             r.op = vca_pkg::OP_STOP_ALL;
    k = $urandom_range(0, 7);
    if (k == 0)      r.src = '0;
    else if (k == 1) r.src = SRC_W'($urandom_range(0, 65535));
    else             r.src = SRC_W'($urandom_range(1, 24));
    r.prio = vca_pkg::PRIO_W'($urandom_range(0, 255));
    r.cls  = vca_pkg::CLASS_W'($urandom_range(0, 1) ? $urandom_range(0, 2)
                                                    : $urandom_range(0, 15));
    if (n > 0 && $urandom_range(0, 3) != 0) r.rel = vca_pkg::REL_W'($urandom_range(0, n - 1));
    else                                    r.rel = vca_pkg::REL_W'($urandom_range(0, 63));
    return r;
  endfunction

  function automatic int pick_gap();
    if (!idle_on || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(1, 17);
  endfunction

  // One request beat; returns at the edge that accepted it, start left high.
  task automatic issue(input voice_req_t r, input int gap, output voice_res_t pred);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start            <= 1'b1;
    req_type_i       <= r.op;
    source_id_i      <= r.src;
    sound_priority_i <= r.prio;
    sound_class_i    <= r.cls;
    release_index_i  <= r.rel;
    do @(posedge clk_i); while (busy);
    predict_outcome(r, pred);
  endtask

  // Sender holds off until every outstanding result is back.
  task automatic drain();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [vca_pkg::CFG_IDX_W-1:0] idx,
                           input logic [vca_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == vca_pkg::CFG_ACTIVE) act_sh = data;
    else                            repl_sh = data[0];
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every done_o beat is matched to the oldest outstanding outcome
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    voice_res_t want;
    if (rst_ni && done_o) begin
      if (pending_outcomes.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, status %0d chan %0d stopped %0d",
                 $time, status_o, channel_index_o, stopped_count_o);
      end else begin
        want = pending_outcomes.pop_front();
        if (status_o !== want.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, want.status, status_o);
        end
        if (channel_index_o !== want.chan) begin
          errors++;
          $display("%0t: channel_index expected %0d got %0d", $time, want.chan, channel_index_o);
        end
        if (stopped_count_o !== want.stopped) begin
          errors++;
          $display("%0t: stopped_count expected %0d got %0d",
                   $time, want.stopped, stopped_count_o);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    voice_res_t pred;
    voice_req_t r;
    int         i;
    int         p;
    int         k;
    rst_ni           <= 1'b0;
    start            <= 1'b0;
    req_type_i       <= vca_pkg::OP_START;
    source_id_i      <= '0;
    sound_priority_i <= '0;
    sound_class_i    <= '0;
    release_index_i  <= '0;
    cfg_valid_i      <= 1'b0;
    cfg_index_i      <= vca_pkg::CFG_ACTIVE;
    cfg_data_i       <= '0;
    clear_shadow();
    calm    = 1'b0;
    idle_on = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table on reset register values
    for (i = 0; i < 24; i++) begin
      issue(dir_rows[i].req, pick_gap(), pred);
      pending_outcomes.push_back(dir_rows[i].fixed ? dir_rows[i].res : pred);
    end
    drain();

    // random phases; registers change only with nothing outstanding
    for (p = 0; p < NUM_PHASES; p++) begin
      write_reg(vca_pkg::CFG_ACTIVE, vca_pkg::CFG_DATA_W'(phase_act[p]));
      // upper data bits are don't-care for replace_mode; toggle them anyway
      write_reg(vca_pkg::CFG_REPLACE, {6'($urandom_range(0, 63)), phase_rep[p][0]});
      calm = (p == NUM_PHASES - 1);
      for (k = 0; k < phase_len[p]; k++) begin
        if (k % 32 == 0) idle_on = !calm && ($urandom_range(0, 2) != 0);
        r = random_request(used_chans());
        issue(r, pick_gap(), pred);
        pending_outcomes.push_back(pred);
      end
      drain();
    end

    // let any stray beat show up before the verdict
    repeat (SCAN_TAIL) @(posedge clk_i);
    if (errors == 0) $display("No mismatches found");
    else             $display("Mismatches found");
    $finish;
  end

endmodule
